// ===== rtl/bdsg_pkg.sv =====
// Shared types and constants for the bilinear density splat grid.
// No dependencies; imported by every module of the block but the checker.
package bdsg_pkg;

  // Default grid size
  localparam int GRID_W_DEF = 128;
  localparam int GRID_H_DEF = 128;

  // Item kinds carried in tuser
  localparam logic [1:0] MODE_SPLAT = 2'd0;
  localparam logic [1:0] MODE_DECAY = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // Register indexes
  localparam logic [2:0] CFG_CENTER_X = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y = 3'd1;
  localparam logic [2:0] CFG_SCALE_X  = 3'd2;
  localparam logic [2:0] CFG_SCALE_Y  = 3'd3;
  localparam logic [2:0] CFG_DECAY    = 3'd4;

  localparam int CFG_DW = 24;

  // Decay factor of one in Q1.16
  localparam logic [16:0] DECAY_ONE = 17'h10000;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [24:0] b;
  } bdsg_mul_req_t;

endpackage

// ===== rtl/bdsg_mult.sv =====
// Shared signed multiplier with a registered product.
// Depends on bdsg_pkg for the operand struct.
module bdsg_mult
  import bdsg_pkg::*;
(
  input  logic               clk,
  input  bdsg_mul_req_t      req,
  output logic signed [57:0] prod
);

  // One product per cycle, available the cycle after the operands
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

endmodule

// ===== rtl/bdsg_ram.sv =====
// Density cell memory: one write port, one read port, registered read data.
// Depends on bdsg_pkg for the default depth; no reset, cleared by a sweep.
module bdsg_ram
  import bdsg_pkg::*;
#(
  parameter int DEPTH = GRID_W_DEF * GRID_H_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bilinear_density_splat_grid.sv =====
// Splat item: mapping (ST_MULX, ST_MULY, ST_MAP), then four neighbors, each read in ST_NBR
// and accumulated in ST_ACC. Read item: ST_RD, ST_RDW. Unused kind: straight to ST_DONE.
// Decay item: ST_DRD, ST_DMUL, ST_DWR for each cell, or a clearing sweep when the factor is
// zero. One memory port pair and one shared multiplier serve all of these. One item at a
// time; s_tready is high only when idle. Reset (synchronous, rst high) starts a clearing
// pass over every cell, during which no item is accepted; config writes are still taken.
module bilinear_density_splat_grid
  import bdsg_pkg::*;
#(
  parameter int GRID_W = GRID_W_DEF,
  parameter int GRID_H = GRID_H_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input items
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,   // pos_x[23:0], pos_y[47:24], cell_x[54:48], cell_y[61:55]
  input  logic [1:0]        s_tuser,   // mode[1:0]
  input  logic              s_tlast,   // last_in_frame
  // result items
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [39:0]       m_tdata,   // cell_count[31:0], cells_hit[34:32]
  output logic              m_tlast,   // batch_done
  // configuration
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic signed [42:0] TEXEL_OFS_X = 43'(GRID_W * 128 - 128);
  localparam logic signed [42:0] TEXEL_OFS_Y = 43'(GRID_H * 128 - 128);

  typedef enum logic [12:0] {
    ST_CLEAR = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_MULX  = 13'b0000000000100,
    ST_MULY  = 13'b0000000001000,
    ST_MAP   = 13'b0000000010000,
    ST_NBR   = 13'b0000000100000,
    ST_ACC   = 13'b0000001000000,
    ST_DRD   = 13'b0000010000000,
    ST_DMUL  = 13'b0000100000000,
    ST_DWR   = 13'b0001000000000,
    ST_RD    = 13'b0010000000000,
    ST_RDW   = 13'b0100000000000,
    ST_DONE  = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // Configuration registers
  logic signed [23:0] center_x, center_y;
  logic [23:0]        scale_x, scale_y;
  logic [16:0]        decay_factor;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      scale_x      <= 24'h010000;
      scale_y      <= 24'h010000;
      decay_factor <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x     <= cfg_wdata;
        CFG_CENTER_Y: center_y     <= cfg_wdata;
        CFG_SCALE_X:  scale_x      <= cfg_wdata;
        CFG_SCALE_Y:  scale_y      <= cfg_wdata;
        CFG_DECAY:    decay_factor <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  // Factors above one act as one
  logic [16:0] decay_sat;
  assign decay_sat = (decay_factor[16] && (decay_factor[15:0] != '0)) ? DECAY_ONE
                                                                       : decay_factor;

  // Latched item
  logic [1:0]         mode;
  logic signed [23:0] pos_x, pos_y;
  logic [6:0]         cell_x, cell_y;
  logic               last;

  // Working registers
  logic [AW-1:0]      addr;          // sweep address
  logic               clr_for_decay; // clear sweep belongs to a decay item
  logic signed [34:0] x0, y0;
  logic [7:0]         sx, sy;
  logic [1:0]         nbr;
  logic [2:0]         hits;
  logic [31:0]        count;

  // Output register
  logic [31:0] out_count;
  logic [2:0]  out_hits;
  logic        out_last;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Shared multiplier and memory
  bdsg_mul_req_t      mreq;
  logic signed [57:0] prod;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [31:0]        mem_wdata, mem_rdata;

  bdsg_mult u_mult (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  bdsg_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] xv, input logic [AW-1:0] yv);
    return yv * AW'(GRID_W) + xv;
  endfunction

  // Differences to the view center
  logic signed [24:0] dx, dy;
  assign dx = {pos_x[23], pos_x} - {center_x[23], center_x};
  assign dy = {pos_y[23], pos_y} - {center_y[23], center_y};

  // Texel coordinate in Q.8 from the product in flight
  logic signed [42:0] texel_x, texel_y;
  assign texel_x = {prod[57], prod[57:16]} + TEXEL_OFS_X;
  assign texel_y = {prod[57], prod[57:16]} + TEXEL_OFS_Y;

  // Current neighbor
  logic signed [35:0] nx, ny;
  logic               nbr_in;
  logic [8:0]         wx, wy;
  assign nx     = {x0[34], x0} + 36'(nbr[0]);
  assign ny     = {y0[34], y0} + 36'(nbr[1]);
  assign nbr_in = !nx[35] && (nx < 36'(GRID_W)) && !ny[35] && (ny < 36'(GRID_H));
  assign wx     = nbr[0] ? {1'b0, sx} : 9'd256 - {1'b0, sx};
  assign wy     = nbr[1] ? {1'b0, sy} : 9'd256 - {1'b0, sy};

  // Saturating accumulate
  logic [32:0] acc_sum;
  assign acc_sum = {1'b0, mem_rdata} + {16'b0, prod[16:0]};

  logic read_in;
  assign read_in = (32'(cell_x) < 32'(GRID_W)) && (32'(cell_y) < 32'(GRID_H));

  // Datapath steering
  always_comb begin
    mreq      = '0;
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    mem_raddr = addr;
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_MULX: begin
        mreq.a = {{8{dx[24]}}, dx};
        mreq.b = {1'b0, scale_x};
      end
      ST_MULY: begin
        mreq.a = {{8{dy[24]}}, dy};
        mreq.b = {1'b0, scale_y};
      end
      ST_NBR: begin
        mreq.a    = {24'b0, wx};
        mreq.b    = {16'b0, wy};
        mem_raddr = cell_addr(nx[AW-1:0], ny[AW-1:0]);
      end
      ST_ACC: begin
        mem_we    = nbr_in;
        mem_waddr = cell_addr(nx[AW-1:0], ny[AW-1:0]);
        mem_wdata = acc_sum[32] ? '1 : acc_sum[31:0];
      end
      ST_DMUL: begin
        mreq.a = {1'b0, mem_rdata};
        mreq.b = {8'b0, decay_sat};
      end
      ST_DWR: begin
        mem_we    = 1'b1;
        mem_wdata = prod[47:16];
      end
      ST_RD: mem_raddr = cell_addr(AW'(cell_x), AW'(cell_y));
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (addr == LAST_ADDR) state_next = clr_for_decay ? ST_DONE : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            MODE_SPLAT: state_next = ST_MULX;
            MODE_DECAY: state_next = (decay_sat == '0) ? ST_CLEAR : ST_DRD;
            MODE_READ:  state_next = ST_RD;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_MULX: state_next = ST_MULY;
      ST_MULY: state_next = ST_MAP;
      ST_MAP:  state_next = ST_NBR;
      ST_NBR:  state_next = ST_ACC;
      ST_ACC:  state_next = (nbr == 2'd3) ? ST_DONE : ST_NBR;
      ST_DRD:  state_next = ST_DMUL;
      ST_DMUL: state_next = ST_DWR;
      ST_DWR:  state_next = (addr == LAST_ADDR) ? ST_DONE : ST_DRD;
      ST_RD:   state_next = ST_RDW;
      ST_RDW:  state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      addr          <= '0;
      clr_for_decay <= 1'b0;
      nbr           <= '0;
      hits          <= '0;
    end else begin
      unique case (state)
        ST_CLEAR, ST_DWR: addr <= (addr == LAST_ADDR) ? '0 : addr + 1'b1;
        ST_IDLE: begin
          addr          <= '0;
          nbr           <= '0;
          hits          <= '0;
          clr_for_decay <= 1'b1;
        end
        ST_ACC: begin
          nbr  <= nbr + 1'b1;
          hits <= hits + 3'(nbr_in);
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode   <= s_tuser;
      pos_x  <= s_tdata[23:0];
      pos_y  <= s_tdata[47:24];
      cell_x <= s_tdata[54:48];
      cell_y <= s_tdata[61:55];
      last   <= s_tlast;
      count  <= '0;
    end
    if (state == ST_MULY) begin
      x0 <= texel_x[42:8];
      sx <= texel_x[7:0];
    end
    if (state == ST_MAP) begin
      y0 <= texel_y[42:8];
      sy <= texel_y[7:0];
    end
    if (state == ST_RDW) begin
      count <= read_in ? mem_rdata : '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      out_count <= (mode == MODE_READ) ? count : '0;
      out_hits  <= (mode == MODE_SPLAT) ? hits : '0;
      out_last  <= last;
    end
  end

  assign m_tdata = {5'b0, out_hits, out_count};
  assign m_tlast = out_last;

endmodule

// ===== rtl/bdsg_checker.sv =====
// Port-level checks for the bilinear density splat grid.
// Depends on the top level's ports; attached by the bind at the end.
module bdsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // Clearing pass holds off items after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("item port ready during clearing pass");

  // One item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after an accepted item");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // At most four neighbors, and a splat result carries no count
  a_hits_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:32] <= 3'd4)
    else $error("cells_hit above four");

  a_hits_no_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[34:32] != 3'd0) |-> (m_tdata[31:0] == 32'd0))
    else $error("splat result with nonzero count");

endmodule

bind bilinear_density_splat_grid bdsg_checker u_bdsg_checker (.*);

// ===== tb/tb.sv =====
// Testbench for bilinear_density_splat_grid: drives splat, decay, read and idle items
// through the stream ports and checks each result against a grid model held here.
// Depends on rtl/bdsg_pkg.sv and the block's top module.
`timescale 1ns / 100ps

module tb
  import bdsg_pkg::*;
();

  localparam int GW = GRID_W_DEF;
  localparam int GH = GRID_H_DEF;
  localparam longint LIMIT = 40_000_000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] px;
    logic [23:0] py;
    logic [6:0]  cx;
    logic [6:0]  cy;
    logic        lst;
  } pt_item_t;

  typedef struct packed {
    logic [31:0] count;
    logic [2:0]  hit;
    logic        done;
  } cell_res_t;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready, s_tlast = 0;
  logic [63:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 0, m_tlast;
  logic [39:0] m_tdata;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  bilinear_density_splat_grid dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // grid model
  logic signed [23:0] ctr_x, ctr_y;
  logic [23:0] scl_x, scl_y;
  logic [16:0] decay_f;
  logic [31:0] grid_q [GW*GH];

  pt_item_t pending_items[$];
  cell_res_t expected_results[$];
  int errors = 0;
  bit quiet = 0;
  longint cycles = 0;

  task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  function automatic longint texel_q8(logic signed [23:0] p, logic signed [23:0] c,
                                      logic [23:0] s, int g);
    longint d, prod, t;
    d = longint'(p) - longint'(c);
    prod = d * longint'({1'b0, s});
    t = prod >>> 16;
    return t + g * 128 - 128;
  endfunction

  function automatic bit add_weight(longint x, longint y, longint w);
    longint sum;
    if (x < 0 || x >= GW || y < 0 || y >= GH) return 0;
    sum = longint'(grid_q[y*GW+x]) + w;
    grid_q[y*GW+x] = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
    return 1;
  endfunction

  function automatic cell_res_t predict_cell(pt_item_t it);
    cell_res_t r;
    longint fx, fy, x0, y0, sx, sy, f;
    r = '0;
    r.done = it.lst;
    case (it.mode)
      MODE_SPLAT: begin
        fx = texel_q8(it.px, ctr_x, scl_x, GW);
        fy = texel_q8(it.py, ctr_y, scl_y, GH);
        x0 = fx >>> 8; y0 = fy >>> 8;
        sx = fx - x0*256; sy = fy - y0*256;
        r.hit = add_weight(x0, y0, (256-sx)*(256-sy)) + add_weight(x0+1, y0, sx*(256-sy))
              + add_weight(x0, y0+1, (256-sx)*sy) + add_weight(x0+1, y0+1, sx*sy);
      end
      MODE_DECAY: begin
        f = (decay_f > DECAY_ONE) ? 65536 : decay_f;
        for (int i = 0; i < GW*GH; i++) grid_q[i] = 32'((longint'(grid_q[i]) * f) >> 16);
      end
      MODE_READ: if (it.cx < GW && it.cy < GH) r.count = grid_q[it.cy*GW + it.cx];
      default: ;
    endcase
    return r;
  endfunction

  // driver
  bit in_acc = 0;
  int src_gap = 0, snk_gap = 0;
  pt_item_t cur;

  // note accepted items at the rising edge for the falling-edge driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_acc <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      expected_results.push_back(predict_cell(cur));
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_acc) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_tvalid <= 0;
        end else if (pending_items.size() > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            src_gap <= $urandom_range(1, 18);
            s_tvalid <= 0;
          end else begin
            cur = pending_items.pop_front();
            s_tdata <= {2'b0, cur.cy, cur.cx, cur.py, cur.px};
            s_tuser <= cur.mode;
            s_tlast <= cur.lst;
            s_tvalid <= 1;
          end
        end else s_tvalid <= 0;
      end
      // sink stalls
      if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        m_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        snk_gap <= $urandom_range(1, 18);
        m_tready <= 0;
      end else m_tready <= 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    cell_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) report("unexpected result", m_tdata, '0);
      else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.count)
          report("cell_count", 40'(m_tdata[31:0]), 40'(want.count));
        if (m_tdata[34:32] !== want.hit)
          report("cells_hit", 40'(m_tdata[34:32]), 40'(want.hit));
        if (m_tlast !== want.done) report("batch_done", 40'(m_tlast), 40'(want.done));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v[CFG_DW-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_CENTER_X: ctr_x = v[23:0];
      CFG_CENTER_Y: ctr_y = v[23:0];
      CFG_SCALE_X: scl_x = v[23:0];
      CFG_SCALE_Y: scl_y = v[23:0];
      CFG_DECAY: decay_f = v[16:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_item(logic [1:0] m, logic [31:0] x, logic [31:0] y,
                          logic [31:0] cx, logic [31:0] cy);
    pt_item_t it;
    it.mode = m; it.px = x[23:0]; it.py = y[23:0]; it.cx = cx[6:0]; it.cy = cy[6:0];
    it.lst = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
  endtask

  // random items: decays by decay_pct, splats mostly near the view, reads at random cells
  task automatic random_phase(int n, int decay_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < decay_pct) add_item(MODE_DECAY, $urandom, $urandom, $urandom, $urandom);
      else if (r < 55) add_item(MODE_SPLAT, ctr_x + $signed($urandom_range(0, 40000)) - 20000,
                                ctr_y + $signed($urandom_range(0, 40000)) - 20000, 0, 0);
      else if (r < 62) add_item(MODE_SPLAT, $urandom, $urandom, 0, 0);
      else if (r < 95) add_item(MODE_READ, $urandom, $urandom, $urandom, $urandom);
      else add_item(MODE_NOP, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    ctr_x = 0; ctr_y = 0; scl_x = 24'h10000; scl_y = 24'h10000; decay_f = 0;
    for (int i = 0; i < GW*GH; i++) grid_q[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 0;

    // directed: extremes, every kind, edges of the grid
    add_item(MODE_READ, 0, 0, 0, 0);
    add_item(MODE_SPLAT, 0, 0, 0, 0);
    add_item(MODE_SPLAT, 24'h7FFFFF, 24'h800000, 0, 0);
    add_item(MODE_SPLAT, 24'h800000, 24'h7FFFFF, 0, 0);
    add_item(MODE_SPLAT, -24'sd16384, -24'sd16384, 0, 0);
    add_item(MODE_SPLAT, 24'sd16256, 24'sd16256, 0, 0);
    add_item(MODE_SPLAT, 24'sd16300, -24'sd16400, 0, 0);
    add_item(MODE_READ, 0, 0, 64, 64);
    add_item(MODE_READ, 0, 0, 63, 63);
    add_item(MODE_READ, 24'hFFFFFF, 24'hFFFFFF, 127, 127);
    add_item(MODE_READ, 0, 0, 0, 127);
    add_item(MODE_NOP, 24'hFFFFFF, 24'hFFFFFF, 127, 127);
    add_item(MODE_DECAY, 0, 0, 0, 0);
    add_item(MODE_READ, 0, 0, 64, 64);
    drain();

    cfg_write(CFG_SCALE_X, 24'hFFFFFF);
    cfg_write(CFG_SCALE_Y, 24'h0);
    cfg_write(CFG_DECAY, 17'h10000);
    for (int i = 0; i < 6; i++) add_item(MODE_SPLAT, i, 0, 0, 0);
    add_item(MODE_DECAY, 0, 0, 0, 0);
    add_item(MODE_READ, 0, 0, 64, 63);
    add_item(MODE_READ, 0, 0, 65, 63);
    drain();

    cfg_write(CFG_CENTER_X, 24'h7FFFFF);
    cfg_write(CFG_CENTER_Y, 24'h800000);
    cfg_write(CFG_SCALE_X, 24'h8000);
    cfg_write(CFG_SCALE_Y, 24'h20000);
    cfg_write(CFG_DECAY, 17'h1FFFF);
    random_phase(250, 1);
    drain();

    cfg_write(CFG_CENTER_X, $urandom);
    cfg_write(CFG_CENTER_Y, $urandom);
    cfg_write(CFG_SCALE_X, $urandom_range(4096, 600000));
    cfg_write(CFG_SCALE_Y, $urandom_range(4096, 600000));
    cfg_write(CFG_DECAY, $urandom_range(1, 65535));
    random_phase(350, 1);
    drain();

    // unit scale at the origin, a zero decay factor that clears the grid, and no stalls
    cfg_write(CFG_CENTER_X, 0);
    cfg_write(CFG_CENTER_Y, 0);
    cfg_write(CFG_SCALE_X, 24'h10000);
    cfg_write(CFG_SCALE_Y, 24'h10000);
    cfg_write(CFG_DECAY, 17'h0);
    quiet = 1;
    random_phase(350, 1);
    drain();

    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
